// ===== rtl/svalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types and constants of the synthesizer voice allocator: default
// sizes, fixed field widths, controller states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package svalloc_pkg;

  localparam int unsigned VOICES_DEF    = 16;
  localparam int unsigned TIME_BITS_DEF = 24;

  // Fixed widths of the voice number and count fields
  localparam int unsigned VNUM_W  = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } svalloc_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the event word, restart the sweep
    logic rd_step;  // read the next voice time, advance the sweep index
    logic commit;   // pick a voice, write it back, register the result
  } svalloc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sweep_end;  // every opened voice has been read
  } svalloc_sts_t;

endpackage

// ===== rtl/svalloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// svalloc_ctrl
// Sequencer of the voice allocator: accept an event, step the countdown
// sweep over the opened voices, then commit the voice choice.
// ----------------------------------------------------------------------------
module svalloc_ctrl
  import svalloc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  svalloc_sts_t sts_i,
  output svalloc_cmd_t cmd_o,
  output logic         busy_o
);

  svalloc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    busy_o        = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // last read data is written back during the final sweep cycle
        if (sts_i.sweep_end) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.rd_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/svalloc_dp.sv =====
// ----------------------------------------------------------------------------
// svalloc_dp
// Datapath of the voice allocator: voice time memory, held bits, open
// count, countdown pipeline, free-voice search and result registers.
// ----------------------------------------------------------------------------
module svalloc_dp
  import svalloc_pkg::*;
#(
  parameter int unsigned VOICES    = VOICES_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  svalloc_cmd_t         cmd_i,
  output svalloc_sts_t         sts_o,
  input  logic [TIME_BITS-1:0] wait_time_i,
  input  logic                 continues_voice_i,
  input  logic [VNUM_W-1:0]    prev_voice_i,
  input  logic                 sets_duration_i,
  input  logic [TIME_BITS-1:0] new_duration_i,
  input  logic                 later_used_i,
  output logic                 done_o,
  output logic [VNUM_W-1:0]    voice_number_o,
  output logic                 opened_new_o,
  output logic                 overflow_o,
  output logic [COUNT_W-1:0]   voices_in_use_o
);

  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CNT_W  = $clog2(VOICES + 1);

  // Event word
  logic [TIME_BITS-1:0] wait_q, dur_q;
  logic                 cont_q, set_dur_q, later_q;
  logic [VNUM_W-1:0]    prev_q;

  // Voice state
  logic [TIME_BITS-1:0] time_mem [VOICES];
  logic [VOICES-1:0]    held_q;
  logic [CNT_W-1:0]     open_q;

  // Sweep pipeline
  logic [CNT_W-1:0]     rd_cnt_q;
  logic [VIDX_W-1:0]    rd_idx;
  logic                 rd_vld_q;
  logic [VIDX_W-1:0]    wr_idx_q;
  logic [TIME_BITS-1:0] rd_time_q;
  logic [TIME_BITS-1:0] sat_time;
  logic                 found_q;
  logic [VIDX_W-1:0]    free_idx_q;

  // Commit decision
  logic                 prev_ok;
  logic                 table_full;
  logic [VIDX_W-1:0]    chosen;
  logic                 opened;
  logic                 ovf;
  logic                 time_we;

  // Memory port
  logic                 mem_we;
  logic [VIDX_W-1:0]    mem_wa;
  logic [TIME_BITS-1:0] mem_wd;

  // Result registers
  logic                 done_q;
  logic [VNUM_W-1:0]    vnum_q;
  logic                 opened_q, ovf_q;

  assign rd_idx          = rd_cnt_q[VIDX_W-1:0];
  assign sts_o.sweep_end = (rd_cnt_q == open_q);

  assign sat_time = (rd_time_q < wait_q) ? '0 : (rd_time_q - wait_q);

  assign prev_ok    = (32'(prev_q) < VOICES);
  assign table_full = (open_q == CNT_W'(VOICES));

  always_comb begin
    chosen = '0;
    opened = 1'b0;
    ovf    = 1'b0;
    if (cont_q) begin
      chosen = VIDX_W'(prev_q);
      ovf    = !prev_ok;
    end else if (found_q) begin
      chosen = free_idx_q;
    end else if (!table_full) begin
      chosen = open_q[VIDX_W-1:0];
      opened = 1'b1;
    end else begin
      ovf = 1'b1;
    end
  end

  // a freshly opened voice starts at zero time unless the event sets a duration
  assign time_we = !ovf && (set_dur_q || opened);

  always_comb begin
    if (rd_vld_q) begin
      mem_we = 1'b1;
      mem_wa = wr_idx_q;
      mem_wd = sat_time;
    end else begin
      mem_we = cmd_i.commit && time_we;
      mem_wa = chosen;
      mem_wd = set_dur_q ? dur_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_step) begin
      rd_time_q <= time_mem[rd_idx];
    end
  end

  // Event capture and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wait_q    <= wait_time_i;
      cont_q    <= continues_voice_i;
      prev_q    <= prev_voice_i;
      set_dur_q <= sets_duration_i;
      dur_q     <= new_duration_i;
      later_q   <= later_used_i;
    end
    if (cmd_i.rd_step) begin
      wr_idx_q <= rd_idx;
    end
    if (rd_vld_q && !found_q) begin
      free_idx_q <= wr_idx_q;
    end
    if (cmd_i.commit) begin
      vnum_q   <= ovf ? '0 : VNUM_W'(chosen);
      opened_q <= opened;
      ovf_q    <= ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      held_q   <= '0;
      open_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q   <= cmd_i.commit;
      rd_vld_q <= cmd_i.rd_step;
      if (cmd_i.load) begin
        rd_cnt_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (cmd_i.rd_step) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
        if (rd_vld_q && !held_q[wr_idx_q] && (sat_time == '0)) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit && !ovf) begin
        held_q[chosen] <= later_q;
      end
      if (cmd_i.commit && opened) begin
        open_q <= open_q + 1'b1;
      end
    end
  end

  assign done_o          = done_q;
  assign voice_number_o  = vnum_q;
  assign opened_new_o    = opened_q;
  assign overflow_o      = ovf_q;
  assign voices_in_use_o = COUNT_W'(open_q);

endmodule

// ===== rtl/synth_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Assigns each note event to a voice of a fixed table, counting down the
// remaining time of every opened voice by the event's wait.
// ----------------------------------------------------------------------------
// Usage:
//   Present an event word on the *_i fields and raise start; the word is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high while the event is processed.
//   Exactly one result word follows each event: done_o pulses for a single
//   cycle with voice_number_o, opened_new_o, overflow_o and voices_in_use_o.
//   The receiver cannot stall; sample the result in the done_o cycle.
// Timing:
//   busy stays high while the opened voices are swept and the choice is
//   committed; the one-read port of the voice time memory lets the sweep
//   read one voice per cycle. A new event may be accepted in the done_o
//   cycle, so an event is not taken while the previous one is in flight.
// Reset:
//   rst_ni clears the open count, held bits and control; the time memory
//   needs no clearing since a voice slot is written (zero or the new duration) when it is opened.
// ----------------------------------------------------------------------------
module synth_voice_allocator
  import svalloc_pkg::*;
#(
  parameter int unsigned VOICES    = VOICES_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [TIME_BITS-1:0] wait_time_i,
  input  logic                 continues_voice_i,
  input  logic [VNUM_W-1:0]    prev_voice_i,
  input  logic                 sets_duration_i,
  input  logic [TIME_BITS-1:0] new_duration_i,
  input  logic                 later_used_i,
  output logic                 done_o,
  output logic [VNUM_W-1:0]    voice_number_o,
  output logic                 opened_new_o,
  output logic                 overflow_o,
  output logic [COUNT_W-1:0]   voices_in_use_o
);

  svalloc_cmd_t cmd;
  svalloc_sts_t sts;

  // Sequence the event: capture, sweep the opened voices, commit
  svalloc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Hold voice state, count down, search the free voice, register results
  svalloc_dp #(
    .VOICES    (VOICES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .wait_time_i       (wait_time_i),
    .continues_voice_i (continues_voice_i),
    .prev_voice_i      (prev_voice_i),
    .sets_duration_i   (sets_duration_i),
    .new_duration_i    (new_duration_i),
    .later_used_i      (later_used_i),
    .done_o            (done_o),
    .voice_number_o    (voice_number_o),
    .opened_new_o      (opened_new_o),
    .overflow_o        (overflow_o),
    .voices_in_use_o   (voices_in_use_o)
  );

`ifndef SYNTH
  // a result word only follows a commit
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd.commit))
    else $error("result strobe without commit");

  // an accepted word keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // overflow reports voice zero and never an opened voice
  a_overflow_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> (voice_number_o == '0) && !opened_new_o)
    else $error("overflow result inconsistent");

  // opening a voice leaves at least one voice in use
  a_open_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && opened_new_o) |-> (voices_in_use_o != '0) || (VOICES >= 32))
    else $error("opened voice not counted");
`endif

endmodule
